// ----- sv/mer_pkg.sv -----
// package for the midpoint ellipse rasterizer
// holds field widths, parameter defaults, the sequencer state type and item codes
// used by every file of the block; depends on nothing
package mer_pkg;

  localparam int unsigned RADIUS_BITS     = 10;
  localparam int unsigned RADIUS_MAX_DEF  = 1023;
  localparam int unsigned COORD_BITS_DEF  = 12;

  localparam int unsigned OFFX_BITS  = 11;
  localparam int unsigned OFFY_BITS  = 12;
  localparam int unsigned SLOPE_BITS = 32;
  localparam int unsigned DEC_BITS   = 48;
  localparam int unsigned SQ_BITS    = 2 * RADIUS_BITS;
  localparam int unsigned SUM_BITS   = 18;

  localparam int unsigned MUL_A_BITS = 24;
  localparam int unsigned MUL_B_BITS = SQ_BITS;
  localparam int unsigned PROD_BITS  = MUL_A_BITS + MUL_B_BITS;

  typedef enum logic [0:0] {
    FUNC_START = 1'b0,
    FUNC_STEP  = 1'b1
  } func_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_RXY,
    ST_INIT,
    ST_R2A,
    ST_R2B,
    ST_R2C,
    ST_R2D,
    ST_R2E,
    ST_R2F,
    ST_EMIT
  } state_t;

endpackage

// ----- sv/mer_mul.sv -----
// shared unsigned multiplier with a registered product
// one product per cycle, used for every square and cross term of the rasterizer
// depends on mer_pkg for operand widths
module mer_mul (
  input  logic                           clk,
  input  logic [mer_pkg::MUL_A_BITS-1:0] op_a,
  input  logic [mer_pkg::MUL_B_BITS-1:0] op_b,
  output logic [mer_pkg::PROD_BITS-1:0]  prod
);

  localparam int PROD_W = mer_pkg::PROD_BITS;

  always_ff @(posedge clk) begin
    prod <= PROD_W'(op_a) * PROD_W'(op_b);
  end

endmodule

// ----- sv/midpoint_ellipse_raster.sv -----
// Midpoint ellipse rasterizer: a start item latches center and radii and, after a short
// multiply sequence, returns the first four-way symmetric point set; each step item then
// returns the next set, region 1 first, then region 2, with the final set flagged last.
// A start item runs SQX, SQY, RXY and INIT, then EMIT registers its result; with no
// region-1 points, setup states R2A to R2F come first. A step item is taken only while the
// result slot is free, its result registered for the next cycle; the step leaving region 1
// is followed by R2A to R2F before the next item is taken. The single shared multiplier
// yields one registered product per cycle. A step while idle gives no result.
// depends on mer_pkg and mer_mul
module midpoint_ellipse_raster #(
  parameter int unsigned RADIUS_MAX = mer_pkg::RADIUS_MAX_DEF,
  parameter int unsigned COORD_BITS = mer_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  logic                                func,
  input  logic signed [COORD_BITS-1:0]        center_x,
  input  logic signed [COORD_BITS-1:0]        center_y,
  input  logic [mer_pkg::RADIUS_BITS-1:0]     radius_x,
  input  logic [mer_pkg::RADIUS_BITS-1:0]     radius_y,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic signed [COORD_BITS:0]          x_right,
  output logic signed [COORD_BITS:0]          x_left,
  output logic signed [COORD_BITS:0]          y_top,
  output logic signed [COORD_BITS:0]          y_bottom,
  output logic                                in_region_two,
  output logic                                last
);

  localparam int RADIUS_W = mer_pkg::RADIUS_BITS;
  localparam int OFFX_W   = mer_pkg::OFFX_BITS;
  localparam int OFFY_W   = mer_pkg::OFFY_BITS;
  localparam int SLOPE_W  = mer_pkg::SLOPE_BITS;
  localparam int DEC_W    = mer_pkg::DEC_BITS;
  localparam int SQ_W     = mer_pkg::SQ_BITS;
  localparam int SUM_W    = mer_pkg::SUM_BITS;
  localparam int MA_W     = mer_pkg::MUL_A_BITS;
  localparam int MB_W     = mer_pkg::MUL_B_BITS;
  localparam int PROD_W   = mer_pkg::PROD_BITS;

  localparam int unsigned RADIUS_TOP = (1 << RADIUS_W) - 1;
  localparam logic [RADIUS_W-1:0] RCLIP =
    (RADIUS_MAX > RADIUS_TOP) ? RADIUS_W'(RADIUS_TOP) : RADIUS_W'(RADIUS_MAX);

  mer_pkg::state_t state, state_next;

  logic busy, pend;

  logic [RADIUS_W-1:0]              rx, ry;
  logic signed [COORD_BITS-1:0]     cx, cy;
  logic [SQ_W-1:0]                  rxsq, rysq;
  logic [MA_W-1:0]                  asq, bsq;
  logic [OFFX_W-1:0]                offx;
  logic signed [OFFY_W-1:0]         offy;
  logic signed [SLOPE_W-1:0]        sx, sy;
  logic signed [DEC_W-1:0]          dec;
  logic                             region;

  logic [MA_W-1:0]   mul_a;
  logic [MB_W-1:0]   mul_b;
  logic [PROD_W-1:0] prod;

  logic slot_free, accept, do_emit, emit_trans;

  logic [RADIUS_W-1:0]        rx_sat, ry_sat;
  logic signed [SLOPE_W-1:0]  two_rxsq, two_rysq, sx_inc, sy_dec, sy_r1;
  logic signed [DEC_W-1:0]    dec_r1_keep, dec_r1_diag, dec_r2_keep, dec_r2_diag;
  logic signed [DEC_W-1:0]    dec_init;
  logic [OFFY_W:0]            a_val;
  logic signed [OFFY_W:0]     b_val;
  logic [OFFY_W-1:0]          b_abs;
  logic signed [SUM_W-1:0]    sum_xr, sum_xl, sum_yt, sum_yb;

  mer_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  assign slot_free  = !result_valid || !result_stall;
  assign item_stall = !((state == mer_pkg::ST_IDLE) && slot_free);
  assign accept     = item_valid && !item_stall;

  assign rx_sat = (radius_x > RCLIP) ? RCLIP : radius_x;
  assign ry_sat = (radius_y > RCLIP) ? RCLIP : radius_y;

  // step arithmetic
  assign two_rxsq = SLOPE_W'({rxsq, 1'b0});
  assign two_rysq = SLOPE_W'({rysq, 1'b0});
  assign sx_inc   = sx + two_rysq;
  assign sy_dec   = sy - two_rxsq;
  assign sy_r1    = dec[DEC_W-1] ? sy : sy_dec;

  assign dec_r1_keep = dec + ((DEC_W'(rysq) + DEC_W'(sx_inc)) << 2);
  assign dec_r1_diag = dec + ((DEC_W'(rysq) + DEC_W'(sx_inc) - DEC_W'(sy_dec)) << 2);
  assign dec_r2_keep = dec + ((DEC_W'(rxsq) - DEC_W'(sy_dec)) << 2);
  assign dec_r2_diag = dec + ((DEC_W'(rxsq) - DEC_W'(sy_dec) + DEC_W'(sx_inc)) << 2);

  assign emit_trans = !region && !(sx_inc < sy_r1);

  // region-1 start value, prod holds rx^2 * ry here
  assign dec_init = (DEC_W'(rysq) << 2) - (DEC_W'(prod) << 2) + DEC_W'(rxsq);

  // region-2 entry operands
  assign a_val = {1'b0, offx, 1'b1};
  assign b_val = (OFFY_W + 1)'(offy) - (OFFY_W + 1)'(1);
  assign b_abs = b_val[OFFY_W] ? OFFY_W'(-b_val) : OFFY_W'(b_val);

  assign sum_xr = SUM_W'(cx) + SUM_W'(offx);
  assign sum_xl = SUM_W'(cx) - SUM_W'(offx);
  assign sum_yt = SUM_W'(cy) + SUM_W'(offy);
  assign sum_yb = SUM_W'(cy) - SUM_W'(offy);

  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    do_emit    = 1'b0;
    unique case (state)
      mer_pkg::ST_IDLE: begin
        if (accept) begin
          if (func == mer_pkg::FUNC_START) begin
            state_next = mer_pkg::ST_SQX;
          end else if (busy) begin
            do_emit = 1'b1;
            if (emit_trans) state_next = mer_pkg::ST_R2A;
          end
        end
      end
      mer_pkg::ST_SQX: begin
        mul_a      = MA_W'(rx);
        mul_b      = MB_W'(rx);
        state_next = mer_pkg::ST_SQY;
      end
      mer_pkg::ST_SQY: begin
        mul_a      = MA_W'(ry);
        mul_b      = MB_W'(ry);
        state_next = mer_pkg::ST_RXY;
      end
      mer_pkg::ST_RXY: begin
        mul_a      = MA_W'(ry);
        mul_b      = rxsq;
        state_next = mer_pkg::ST_INIT;
      end
      mer_pkg::ST_INIT: begin
        state_next = (prod != '0) ? mer_pkg::ST_EMIT : mer_pkg::ST_R2A;
      end
      mer_pkg::ST_R2A: begin
        mul_a      = MA_W'(a_val);
        mul_b      = MB_W'(a_val);
        state_next = mer_pkg::ST_R2B;
      end
      mer_pkg::ST_R2B: begin
        mul_a      = MA_W'(b_abs);
        mul_b      = MB_W'(b_abs);
        state_next = mer_pkg::ST_R2C;
      end
      mer_pkg::ST_R2C: begin
        mul_a      = asq;
        mul_b      = rysq;
        state_next = mer_pkg::ST_R2D;
      end
      mer_pkg::ST_R2D: begin
        mul_a      = bsq;
        mul_b      = rxsq;
        state_next = mer_pkg::ST_R2E;
      end
      mer_pkg::ST_R2E: begin
        mul_a      = MA_W'(rysq);
        mul_b      = rxsq;
        state_next = mer_pkg::ST_R2F;
      end
      mer_pkg::ST_R2F: begin
        state_next = pend ? mer_pkg::ST_EMIT : mer_pkg::ST_IDLE;
      end
      mer_pkg::ST_EMIT: begin
        if (slot_free) begin
          do_emit    = 1'b1;
          state_next = emit_trans ? mer_pkg::ST_R2A : mer_pkg::ST_IDLE;
        end
      end
      default: state_next = mer_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= mer_pkg::ST_IDLE;
      busy         <= 1'b0;
      pend         <= 1'b0;
      result_valid <= 1'b0;
      region       <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= do_emit || (result_valid && result_stall);
      if (accept && func == mer_pkg::FUNC_START) begin
        busy <= 1'b1;
        pend <= 1'b1;
      end
      if (state == mer_pkg::ST_INIT) region <= 1'b0;
      if (state == mer_pkg::ST_R2F) region <= 1'b1;
      if (do_emit) begin
        pend <= 1'b0;
        if (region && offy == '0) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && func == mer_pkg::FUNC_START) begin
      rx <= rx_sat;
      ry <= ry_sat;
      cx <= center_x;
      cy <= center_y;
    end
    unique case (state)
      mer_pkg::ST_SQY: rxsq <= prod[SQ_W-1:0];
      mer_pkg::ST_RXY: rysq <= prod[SQ_W-1:0];
      mer_pkg::ST_INIT: begin
        offx <= '0;
        offy <= OFFY_W'(ry);
        sx   <= '0;
        sy   <= SLOPE_W'({prod, 1'b0});
        dec  <= dec_init;
      end
      mer_pkg::ST_R2B: asq <= prod[MA_W-1:0];
      mer_pkg::ST_R2C: bsq <= prod[MA_W-1:0];
      mer_pkg::ST_R2D: dec <= DEC_W'(prod);
      mer_pkg::ST_R2E: dec <= dec + (DEC_W'(prod) << 2);
      mer_pkg::ST_R2F: dec <= dec - (DEC_W'(prod) << 2);
      default: ;
    endcase
    if (do_emit) begin
      x_right       <= sum_xr[COORD_BITS:0];
      x_left        <= sum_xl[COORD_BITS:0];
      y_top         <= sum_yt[COORD_BITS:0];
      y_bottom      <= sum_yb[COORD_BITS:0];
      in_region_two <= region;
      last          <= region && offy == '0;
      if (!region) begin
        offx <= offx + OFFX_W'(1);
        sx   <= sx_inc;
        if (dec[DEC_W-1]) begin
          dec <= dec_r1_keep;
        end else begin
          offy <= offy - OFFY_W'(1);
          sy   <= sy_dec;
          dec  <= dec_r1_diag;
        end
      end else begin
        offy <= offy - OFFY_W'(1);
        sy   <= sy_dec;
        if (!dec[DEC_W-1] && dec != '0) begin
          dec <= dec_r2_keep;
        end else begin
          offx <= offx + OFFX_W'(1);
          sx   <= sx_inc;
          dec  <= dec_r2_diag;
        end
      end
    end
  end

endmodule

// ----- sv/mer_chk.sv -----
// port-level checker for the midpoint ellipse rasterizer and its bind
// watches item and result handshakes of midpoint_ellipse_raster over time
// depends on mer_pkg for widths and item codes
module mer_chk #(
  parameter int unsigned COORD_BITS = mer_pkg::COORD_BITS_DEF
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            item_valid,
  input logic                            item_stall,
  input logic                            func,
  input logic                            result_valid,
  input logic                            result_stall,
  input logic signed [COORD_BITS:0]      x_right,
  input logic signed [COORD_BITS:0]      x_left,
  input logic signed [COORD_BITS:0]      y_top,
  input logic signed [COORD_BITS:0]      y_bottom,
  input logic                            in_region_two,
  input logic                            last
);

  logic start_accept;

  assign start_accept = item_valid && !item_stall && func == mer_pkg::FUNC_START;

  // a start needs the multiply sequence before its first set
  a_start_latency: assert property (@(posedge clk) disable iff (rst)
    start_accept && !result_valid |=> !result_valid)
    else $error("result appeared one cycle after a start item");

  a_last_region: assert property (@(posedge clk) disable iff (rst)
    result_valid && last |-> in_region_two)
    else $error("last set outside region two");

  // final set has zero y offset
  a_last_row: assert property (@(posedge clk) disable iff (rst)
    result_valid && last |-> y_top == y_bottom)
    else $error("last set with nonzero y offset");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      result_valid && $stable(x_right) && $stable(x_left) && $stable(y_top)
      && $stable(y_bottom) && $stable(in_region_two) && $stable(last))
    else $error("stalled result changed");

endmodule

bind midpoint_ellipse_raster mer_chk #(.COORD_BITS(COORD_BITS)) u_mer_chk (.*);

// ----- dv/midpoint_ellipse_raster_checker.sv -----
// checker for the midpoint ellipse rasterizer: watches both channels, predicts every point set
// from the accepted items and compares each accepted result field by field
// depends on mer_pkg
module midpoint_ellipse_raster_checker #(
  parameter int unsigned RADIUS_MAX = mer_pkg::RADIUS_MAX_DEF,
  parameter int unsigned COORD_BITS = mer_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  input  logic                              item_stall,
  input  logic                              func,
  input  logic signed [COORD_BITS-1:0]      center_x,
  input  logic signed [COORD_BITS-1:0]      center_y,
  input  logic [mer_pkg::RADIUS_BITS-1:0]   radius_x,
  input  logic [mer_pkg::RADIUS_BITS-1:0]   radius_y,
  input  logic                              result_valid,
  input  logic                              result_stall,
  input  logic signed [COORD_BITS:0]        x_right,
  input  logic signed [COORD_BITS:0]        x_left,
  input  logic signed [COORD_BITS:0]        y_top,
  input  logic signed [COORD_BITS:0]        y_bottom,
  input  logic                              in_region_two,
  input  logic                              last,
  output int                                fail_count,
  output int                                outstanding
);

  typedef struct {
    logic signed [COORD_BITS:0] x_right;
    logic signed [COORD_BITS:0] x_left;
    logic signed [COORD_BITS:0] y_top;
    logic signed [COORD_BITS:0] y_bottom;
    logic                       in_region_two;
    logic                       last;
  } point_set_t;

  point_set_t sets_due[$];
  point_set_t want;

  longint off_x, off_y, slope_x, slope_y, decision4;
  longint rx_sq, ry_sq, ctr_x, ctr_y, rad_x, rad_y;
  bit     in_r2, tracing;
  int     fails = 0;

  function automatic void enter_region_two();
    longint a, b;
    a = 2 * off_x + 1;
    b = off_y - 1;
    in_r2 = 1'b1;
    decision4 = ry_sq * a * a + 4 * rx_sq * b * b - 4 * rx_sq * ry_sq;
  endfunction

  function automatic void queue_next_set();
    point_set_t ps;
    longint     t;
    t = ctr_x + off_x;
    ps.x_right = t[COORD_BITS:0];
    t = ctr_x - off_x;
    ps.x_left = t[COORD_BITS:0];
    t = ctr_y + off_y;
    ps.y_top = t[COORD_BITS:0];
    t = ctr_y - off_y;
    ps.y_bottom = t[COORD_BITS:0];
    ps.in_region_two = in_r2;
    ps.last = in_r2 && (off_y == 0);
    sets_due.insert(sets_due.size(), ps);
    if (!in_r2) begin
      off_x++;
      slope_x += 2 * ry_sq;
      if (decision4 < 0) begin
        decision4 += 4 * (ry_sq + slope_x);
      end else begin
        off_y--;
        slope_y -= 2 * rx_sq;
        decision4 += 4 * (ry_sq + slope_x - slope_y);
      end
      if (slope_x >= slope_y) enter_region_two();
    end else begin
      off_y--;
      slope_y -= 2 * rx_sq;
      if (decision4 > 0) begin
        decision4 += 4 * (rx_sq - slope_y);
      end else begin
        off_x++;
        slope_x += 2 * ry_sq;
        decision4 += 4 * (rx_sq - slope_y + slope_x);
      end
      if (off_y < 0) tracing = 1'b0;
    end
  endfunction

  function automatic void check_field(string name, longint exp_val, longint act_val);
    if (exp_val != act_val) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      off_x     = 0;
      off_y     = 0;
      slope_x   = 0;
      slope_y   = 0;
      decision4 = 0;
      rx_sq     = 0;
      ry_sq     = 0;
      ctr_x     = 0;
      ctr_y     = 0;
      in_r2     = 1'b0;
      tracing   = 1'b0;
      sets_due.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (sets_due.size() == 0) begin
          $error("point set with no item waiting: x_right %0d y_top %0d", x_right, y_top);
          fails++;
        end else begin
          want = sets_due.pop_front();
          check_field("x_right", want.x_right, x_right);
          check_field("x_left", want.x_left, x_left);
          check_field("y_top", want.y_top, y_top);
          check_field("y_bottom", want.y_bottom, y_bottom);
          check_field("in_region_two", want.in_region_two, in_region_two);
          check_field("last", want.last, last);
        end
      end
      if (item_valid && !item_stall) begin
        if (func == mer_pkg::FUNC_START) begin
          rad_x     = (radius_x > RADIUS_MAX) ? RADIUS_MAX : radius_x;
          rad_y     = (radius_y > RADIUS_MAX) ? RADIUS_MAX : radius_y;
          ctr_x     = center_x;
          ctr_y     = center_y;
          rx_sq     = rad_x * rad_x;
          ry_sq     = rad_y * rad_y;
          off_x     = 0;
          off_y     = rad_y;
          slope_x   = 0;
          slope_y   = 2 * rx_sq * rad_y;
          decision4 = 4 * ry_sq - 4 * rx_sq * rad_y + rx_sq;
          in_r2     = 1'b0;
          tracing   = 1'b1;
          if (slope_x >= slope_y) enter_region_two();
          queue_next_set();
        end else if (tracing) begin
          queue_next_set();
        end
      end
    end
    fail_count  <= fails;
    outstanding <= sets_due.size();
  end

endmodule

// ----- dv/midpoint_ellipse_raster_tb.sv -----
// testbench top for the midpoint ellipse rasterizer: directed ellipses, then random ones,
// with random gaps on both channels and one long receiver hold-off; gives the verdict
// depends on mer_pkg, midpoint_ellipse_raster and midpoint_ellipse_raster_checker
module midpoint_ellipse_raster_tb;

  localparam int unsigned CB = mer_pkg::COORD_BITS_DEF;
  localparam int unsigned RB = mer_pkg::RADIUS_BITS;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        item_valid = 1'b0;
  logic                        item_stall;
  logic                        func = mer_pkg::FUNC_STEP;
  logic signed [CB-1:0]        center_x = '0;
  logic signed [CB-1:0]        center_y = '0;
  logic [RB-1:0]               radius_x = '0;
  logic [RB-1:0]               radius_y = '0;
  logic                        result_valid;
  logic                        result_stall;
  logic signed [CB:0]          x_right;
  logic signed [CB:0]          x_left;
  logic signed [CB:0]          y_top;
  logic signed [CB:0]          y_bottom;
  logic                        in_region_two;
  logic                        last;

  logic rx_stall = 1'b0;
  logic hold_off = 1'b0;
  int   fail_count;
  int   outstanding;
  int   items_sent = 0;
  int   calm_tx = 0;
  int   calm_rx = 0;

  assign result_stall = rx_stall | hold_off;

  midpoint_ellipse_raster u_dut (.*);

  midpoint_ellipse_raster_checker u_checker (.*);

  initial forever #1 clk = ~clk;

  initial begin
    #400000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic offer_item(input logic f, input logic [CB-1:0] cx, input logic [CB-1:0] cy,
                            input logic [RB-1:0] rx, input logic [RB-1:0] ry);
    int gap;
    if (calm_tx > 0) begin
      gap = 0;
      calm_tx--;
    end else begin
      gap = $urandom_range(0, 6);
      if ($urandom_range(0, 29) == 0) calm_tx = 40;
    end
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    func       <= f;
    center_x   <= cx;
    center_y   <= cy;
    radius_x   <= rx;
    radius_y   <= ry;
    do @(posedge clk); while (item_stall);
    items_sent++;
  endtask

  // step items carry random bits in the unused fields
  task automatic offer_step();
    logic [31:0] r;
    logic [31:0] s;
    r = $urandom;
    s = $urandom;
    offer_item(mer_pkg::FUNC_STEP, r[CB-1:0], r[2*CB-1:CB], s[RB-1:0], s[2*RB-1:RB]);
  endtask

  task automatic offer_ellipse(input logic [CB-1:0] cx, input logic [CB-1:0] cy,
                               input logic [RB-1:0] rx,
                               input logic [RB-1:0] ry, input int steps);
    offer_item(mer_pkg::FUNC_START, cx, cy, rx, ry);
    repeat (steps) offer_step();
  endtask

  // receiver: random stall per item, with calm stretches
  initial begin
    int gap;
    @(negedge rst);
    forever begin
      if (calm_rx > 0) begin
        gap = 0;
        calm_rx--;
      end else begin
        gap = $urandom_range(0, 6);
        if ($urandom_range(0, 24) == 0) calm_rx = 40;
      end
      if (gap > 0) begin
        rx_stall <= 1'b1;
        repeat (gap) @(posedge clk);
        rx_stall <= 1'b0;
      end
      do @(posedge clk); while (!(result_valid && !result_stall));
    end
  end

  // long hold-off so the block fills up and stalls its input
  initial begin
    wait (items_sent >= 200);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    logic [31:0] r;
    int rxi, ryi, pick, kind, steps;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // step while idle
    offer_step();
    // both radii zero, extreme centers
    offer_ellipse(12'h7FF, 12'h800, 10'd0, 10'd0, 1);
    // zero vertical radius, widest horizontal
    offer_ellipse(12'h800, 12'h7FF, 10'd1023, 10'd0, 0);
    // zero horizontal radius, run out plus an idle step
    offer_ellipse(12'h000, 12'h000, 10'd0, 10'd3, 4);
    // large radii, each dropped by a new start
    offer_ellipse(12'h123, 12'hEDC, 10'd1, 10'd1023, 2);
    offer_ellipse(12'h7FF, 12'h7FF, 10'd1023, 10'd1023, 2);
    offer_ellipse(12'h800, 12'h800, 10'd1023, 10'd1, 2);
    offer_ellipse(12'h005, 12'hFFB, 10'd2, 10'd2, 6);

    while (items_sent < 540) begin
      r    = $urandom;
      pick = $urandom_range(0, 19);
      kind = $urandom_range(0, 9);
      if (pick == 0) begin
        rxi = $urandom_range(0, 1023);
        ryi = $urandom_range(0, 3);
      end else if (pick == 1) begin
        rxi = $urandom_range(0, 3);
        ryi = $urandom_range(0, 1023);
      end else if (pick < 5) begin
        rxi = $urandom_range(0, 40);
        ryi = $urandom_range(0, 40);
      end else begin
        rxi = $urandom_range(0, 12);
        ryi = $urandom_range(0, 12);
      end
      if (pick < 2) steps = $urandom_range(0, 8);
      else if (kind == 0) steps = $urandom_range(0, rxi + ryi);
      else steps = rxi + ryi + 1 + $urandom_range(0, 2);
      if (kind == 1) repeat ($urandom_range(1, 3)) offer_step();
      offer_ellipse(r[CB-1:0], r[2*CB-1:CB], rxi[RB-1:0], ryi[RB-1:0], steps);
    end
    item_valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
